@@ hw/rtl/pprd_pkg.sv @@
// Shared constants, register indexes and clamp helpers for the projection pipeline.
package pprd_pkg;

  localparam int unsigned PPRD_FRAC_BITS = 16;
  localparam int unsigned KFRAC          = 28;
  localparam int unsigned CFG_IDX_W      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCAL   = 3'd0,
    CFG_ASPECT  = 3'd1,
    CFG_SKEW    = 3'd2,
    CFG_PRIN_X  = 3'd3,
    CFG_PRIN_Y  = 3'd4,
    CFG_K1      = 3'd5,
    CFG_K2      = 3'd6
  } cfg_idx_e;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  // Clamp a wide signed value to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Report whether sat32 clamps the value
  function automatic logic ovf32(input logic signed [63:0] v);
    return (v > S32_MAX) || (v < S32_MIN);
  endfunction

endpackage

@@ hw/rtl/pinhole_project_radial_distort.sv @@
// Pinhole projection with two-term radial distortion, fully pipelined.
//
// One ray is taken on every cycle that start_i is high (busy_o stays low) and its pixel leaves
// on done_o after one load stage, 32 + FRAC_BITS restoring-division stages for x/z and y/z,
// then thirteen multiply and clamp stages. Results cannot be held off by the receiver; every
// accepted ray produces one done_o pulse. Registers are written through cfg_we_i and take
// effect at once, also on rays in flight; write only while no ray is in flight. A zero depth
// gives zero pixels with zero_depth_o set and saturated_o clear.
module pinhole_project_radial_distort
  import pprd_pkg::*;
#(
  parameter int unsigned FRAC_BITS = PPRD_FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic signed [31:0]   ray_x_i,
  input  logic signed [31:0]   ray_y_i,
  input  logic signed [31:0]   ray_z_i,
  output logic                 done_o,
  output logic signed [31:0]   pixel_x_o,
  output logic signed [31:0]   pixel_y_o,
  output logic                 zero_depth_o,
  output logic                 saturated_o
);

  localparam int unsigned QW  = 32 + FRAC_BITS;
  localparam int unsigned LAT = QW + 14;

  // Configuration registers
  logic [31:0]        focal_q, aspect_q;
  logic signed [31:0] skew_q, prin_x_q, prin_y_q, k1_q, k2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_q  <= 32'(64'd1 << FRAC_BITS);
      aspect_q <= 32'(64'd1 << FRAC_BITS);
      skew_q   <= '0;
      prin_x_q <= '0;
      prin_y_q <= '0;
      k1_q     <= '0;
      k2_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FOCAL:  focal_q  <= cfg_wdata_i;
        CFG_ASPECT: aspect_q <= cfg_wdata_i;
        CFG_SKEW:   skew_q   <= cfg_wdata_i;
        CFG_PRIN_X: prin_x_q <= cfg_wdata_i;
        CFG_PRIN_Y: prin_y_q <= cfg_wdata_i;
        CFG_K1:     k1_q     <= cfg_wdata_i;
        CFG_K2:     k2_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Every cycle takes a ray
  assign busy_o = 1'b0;

  // Division pipeline: stage 0 holds magnitudes, stage i has produced i quotient bits
  logic          dv_vld_q [QW+1];
  logic [QW-1:0] qx_q     [QW+1];
  logic [QW-1:0] qy_q     [QW+1];
  logic [31:0]   rx_q     [QW+1];
  logic [31:0]   ry_q     [QW+1];
  logic [31:0]   dvs_q    [QW+1];
  logic          negx_q   [QW+1];
  logic          negy_q   [QW+1];
  logic          zdep_q   [QW+1];

  logic [31:0] absx, absy, absz;
  assign absx = ray_x_i[31] ? 32'(-ray_x_i) : ray_x_i;
  assign absy = ray_y_i[31] ? 32'(-ray_y_i) : ray_y_i;
  assign absz = ray_z_i[31] ? 32'(-ray_z_i) : ray_z_i;

  // Load the dividers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else begin
      dv_vld_q[0] <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    qx_q[0]   <= QW'({absx, {FRAC_BITS{1'b0}}});
    qy_q[0]   <= QW'({absy, {FRAC_BITS{1'b0}}});
    rx_q[0]   <= '0;
    ry_q[0]   <= '0;
    dvs_q[0]  <= absz;
    negx_q[0] <= ray_x_i[31] ^ ray_z_i[31];
    negy_q[0] <= ray_y_i[31] ^ ray_z_i[31];
    zdep_q[0] <= (ray_z_i == '0);
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    logic [32:0] trx, try_, dfx, dfy;
    logic        bx, by;

    // One restoring step per stage for each quotient
    always_comb begin
      trx  = {rx_q[i], qx_q[i][QW-1]};
      try_ = {ry_q[i], qy_q[i][QW-1]};
      dfx  = trx - {1'b0, dvs_q[i]};
      dfy  = try_ - {1'b0, dvs_q[i]};
      bx   = (trx >= {1'b0, dvs_q[i]});
      by   = (try_ >= {1'b0, dvs_q[i]});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[i+1] <= 1'b0;
      end else begin
        dv_vld_q[i+1] <= dv_vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      rx_q[i+1]   <= bx ? dfx[31:0] : trx[31:0];
      ry_q[i+1]   <= by ? dfy[31:0] : try_[31:0];
      qx_q[i+1]   <= {qx_q[i][QW-2:0], bx};
      qy_q[i+1]   <= {qy_q[i][QW-2:0], by};
      dvs_q[i+1]  <= dvs_q[i];
      negx_q[i+1] <= negx_q[i];
      negy_q[i+1] <= negy_q[i];
      zdep_q[i+1] <= zdep_q[i];
    end
  end

  // Post-division stage valid and flag chain
  logic [13:1] vld_q;
  logic [13:1] zd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[12:1], dv_vld_q[QW]};
    end
  end

  always_ff @(posedge clk_i) begin
    zd_q <= {zd_q[12:1], zdep_q[QW]};
  end

  // Payload registers per stage
  logic signed [31:0] u1_q, v1_q, u2_q, v2_q, u3_q, v3_q, u4_q, v4_q;
  logic signed [31:0] u5_q, v5_q, u6_q, v6_q, u7_q, v7_q;
  logic               s1_q, s2_q, s3_q, s4_q, s5_q, s6_q, s7_q, s8_q;
  logic               s9_q, s10_q, s11_q, s12_q, s13_q;
  logic signed [63:0] uu2_q, vv2_q;
  logic [30:0]        r2_3_q, r2_4_q, r2_5_q;
  logic signed [63:0] p4_q, p6_q, pu8_q, pv8_q;
  logic signed [31:0] t5_q, d7_q;
  logic signed [31:0] ud9_q, vd9_q;
  logic signed [63:0] pa10_q, pb10_q, pc10_q;
  logic signed [31:0] px11_q, w11_q, px12_q;
  logic signed [63:0] pw12_q;
  logic signed [31:0] px13_q, py13_q;

  // Stage-local combinational values
  logic signed [63:0] qxs, qys, t_sum, d_sum, px_sum, w_sh, py_sum;
  logic [63:0]        sq_u, sq_sh;

  always_comb begin
    qxs    = negx_q[QW] ? -64'($signed({1'b0, qx_q[QW]})) : 64'($signed({1'b0, qx_q[QW]}));
    qys    = negy_q[QW] ? -64'($signed({1'b0, qy_q[QW]})) : 64'($signed({1'b0, qy_q[QW]}));
    sq_u   = {1'b0, uu2_q[62:0]} + {1'b0, vv2_q[62:0]};
    sq_sh  = sq_u >> FRAC_BITS;
    t_sum  = 64'(k1_q) + (p4_q >>> FRAC_BITS);
    d_sum  = (64'sd1 <<< KFRAC) + (p6_q >>> FRAC_BITS);
    px_sum = (pa10_q >>> FRAC_BITS) + (pb10_q >>> FRAC_BITS) + 64'(prin_x_q);
    w_sh   = pc10_q >>> FRAC_BITS;
    py_sum = (pw12_q >>> FRAC_BITS) + 64'(prin_y_q);
  end

  always_ff @(posedge clk_i) begin
    // Sign and clamp the quotients
    u1_q  <= sat32(qxs);
    v1_q  <= sat32(qys);
    s1_q  <= ovf32(qxs) | ovf32(qys);
    // Square
    uu2_q <= 64'(u1_q) * 64'(u1_q);
    vv2_q <= 64'(v1_q) * 64'(v1_q);
    u2_q  <= u1_q;  v2_q <= v1_q;  s2_q <= s1_q;
    // Radius squared, clamped to the positive range
    r2_3_q <= (sq_sh > 64'd2147483647) ? 31'h7FFF_FFFF : sq_sh[30:0];
    s3_q   <= s2_q | (sq_sh > 64'd2147483647);
    u3_q   <= u2_q;  v3_q <= v2_q;
    // k2 * r2
    p4_q   <= 64'(k2_q) * 64'($signed({1'b0, r2_3_q}));
    r2_4_q <= r2_3_q;  u4_q <= u3_q;  v4_q <= v3_q;  s4_q <= s3_q;
    // t = k1 + k2*r2
    t5_q   <= sat32(t_sum);
    s5_q   <= s4_q | ovf32(t_sum);
    r2_5_q <= r2_4_q;  u5_q <= u4_q;  v5_q <= v4_q;
    // r2 * t
    p6_q   <= 64'($signed({1'b0, r2_5_q})) * 64'(t5_q);
    u6_q   <= u5_q;  v6_q <= v5_q;  s6_q <= s5_q;
    // Distortion factor
    d7_q   <= sat32(d_sum);
    s7_q   <= s6_q | ovf32(d_sum);
    u7_q   <= u6_q;  v7_q <= v6_q;
    // Scale by the factor
    pu8_q  <= 64'(u7_q) * 64'(d7_q);
    pv8_q  <= 64'(v7_q) * 64'(d7_q);
    s8_q   <= s7_q;
    // Distorted coordinates
    ud9_q  <= sat32(pu8_q >>> KFRAC);
    vd9_q  <= sat32(pv8_q >>> KFRAC);
    s9_q   <= s8_q | ovf32(pu8_q >>> KFRAC) | ovf32(pv8_q >>> KFRAC);
    // Focal and skew products
    pa10_q <= 64'(ud9_q) * 64'($signed({1'b0, focal_q}));
    pb10_q <= 64'(vd9_q) * 64'(skew_q);
    pc10_q <= 64'(vd9_q) * 64'($signed({1'b0, focal_q}));
    s10_q  <= s9_q;
    // Column and scaled row
    px11_q <= sat32(px_sum);
    w11_q  <= sat32(w_sh);
    s11_q  <= s10_q | ovf32(px_sum) | ovf32(w_sh);
    // Aspect product
    pw12_q <= 64'(w11_q) * 64'($signed({1'b0, aspect_q}));
    px12_q <= px11_q;
    s12_q  <= s11_q;
    // Row and output
    px13_q <= px12_q;
    py13_q <= sat32(py_sum);
    s13_q  <= s12_q | ovf32(py_sum);
  end

  // Force zero pixels on zero depth
  assign done_o       = vld_q[13];
  assign zero_depth_o = zd_q[13];
  assign pixel_x_o    = zd_q[13] ? '0 : px13_q;
  assign pixel_y_o    = zd_q[13] ? '0 : py13_q;
  assign saturated_o  = zd_q[13] ? 1'b0 : s13_q;

  // Every accepted ray leaves the pipeline on done_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("ray lost in pipeline");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("result without a ray");

  a_zero_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && zero_depth_o) |-> (pixel_x_o == '0 && pixel_y_o == '0 && !saturated_o))
    else $error("zero-depth result not cleared");

endmodule

@@ tb/sv/pprd_checker.sv @@
// Checker for the projection block: predicts each pixel and compares it with what leaves the block.
module pprd_checker
  import pprd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic               cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic signed [31:0] ray_x_i,
  input  logic signed [31:0] ray_y_i,
  input  logic signed [31:0] ray_z_i,
  input  logic               done_i,
  input  logic signed [31:0] pixel_x_i,
  input  logic signed [31:0] pixel_y_i,
  input  logic               zero_depth_i,
  input  logic               saturated_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 sat_seen_o
);

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               zd;
    logic               sat;
  } pixel_t;

  typedef logic signed [127:0] wide_t;

  pixel_t             pixel_q[$];
  logic [31:0]        focal, aspect;
  logic signed [31:0] skew, prin_x, prin_y, k1, k2;

  // Clamp to signed 32 bits, raising the flag on overflow
  function automatic wide_t clip(input wide_t v, inout logic flag);
    if (v > wide_t'(S32_MAX)) begin
      flag = 1'b1;
      return wide_t'(S32_MAX);
    end
    if (v < wide_t'(S32_MIN)) begin
      flag = 1'b1;
      return wide_t'(S32_MIN);
    end
    return v;
  endfunction

  function automatic pixel_t project_ray(input logic signed [31:0] x, y, z);
    pixel_t res;
    wide_t  u, v, r2, t, d, px, w, py, sq;
    logic   sat;
    sat = 1'b0;
    res = '0;
    if (z == 0) begin
      res.zd = 1'b1;
      return res;
    end
    // Normalise: truncating division
    u  = clip((wide_t'(x) <<< PPRD_FRAC_BITS) / wide_t'(z), sat);
    v  = clip((wide_t'(y) <<< PPRD_FRAC_BITS) / wide_t'(z), sat);
    sq = (u * u + v * v) >>> PPRD_FRAC_BITS;
    if (sq > wide_t'(S32_MAX)) begin
      sat = 1'b1;
      sq  = wide_t'(S32_MAX);
    end
    r2 = sq;
    // Distortion factor in Q4.28
    t  = clip(wide_t'(k1) + ((wide_t'(k2) * r2) >>> PPRD_FRAC_BITS), sat);
    d  = clip((wide_t'(1) <<< KFRAC) + ((r2 * t) >>> PPRD_FRAC_BITS), sat);
    u  = clip((u * d) >>> KFRAC, sat);
    v  = clip((v * d) >>> KFRAC, sat);
    // Map to pixels
    px = clip(((u * wide_t'({1'b0, focal})) >>> PPRD_FRAC_BITS)
              + ((v * wide_t'(skew)) >>> PPRD_FRAC_BITS) + wide_t'(prin_x), sat);
    w  = clip((v * wide_t'({1'b0, focal})) >>> PPRD_FRAC_BITS, sat);
    py = clip(((w * wide_t'({1'b0, aspect})) >>> PPRD_FRAC_BITS) + wide_t'(prin_y), sat);
    res.px  = px[31:0];
    res.py  = py[31:0];
    res.sat = sat;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got, want);
    $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  assign pending_o = pixel_q.size();

  // Track registers, predict on each transfer in, compare on each result
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    if (!rst_ni) begin
      focal  <= 32'h0001_0000;
      aspect <= 32'h0001_0000;
      skew   <= '0;
      prin_x <= '0;
      prin_y <= '0;
      k1     <= '0;
      k2     <= '0;
      pixel_q.delete();
      fail_count_o = 0;
      checked_o    = 0;
      sat_seen_o   = 0;
    end else begin
      if (start_i && !busy_i) pixel_q.push_back(project_ray(ray_x_i, ray_y_i, ray_z_i));
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_FOCAL:  focal  <= cfg_wdata_i;
          CFG_ASPECT: aspect <= cfg_wdata_i;
          CFG_SKEW:   skew   <= cfg_wdata_i;
          CFG_PRIN_X: prin_x <= cfg_wdata_i;
          CFG_PRIN_Y: prin_y <= cfg_wdata_i;
          CFG_K1:     k1     <= cfg_wdata_i;
          CFG_K2:     k2     <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (done_i) begin
        if (pixel_q.size() == 0) begin
          report_mismatch("unexpected result", pixel_x_i, '0);
        end else begin
          want = pixel_q.pop_front();
          checked_o++;
          if (want.sat) sat_seen_o++;
          if (pixel_x_i != want.px) report_mismatch("pixel_x", pixel_x_i, want.px);
          if (pixel_y_i != want.py) report_mismatch("pixel_y", pixel_y_i, want.py);
          if (zero_depth_i != want.zd) report_mismatch("zero_depth", zero_depth_i, want.zd);
          if (saturated_i != want.sat) report_mismatch("saturated", saturated_i, want.sat);
        end
      end
    end
  end

endmodule

@@ tb/sv/tb_pinhole_project_radial_distort.sv @@
// Top of the projection testbench: clock, reset, stimulus, watchdog and verdict.
module tb_pinhole_project_radial_distort;
  import pprd_pkg::*;

  localparam int RANDOM_RAYS = 750;
  localparam int DRAIN_WAIT  = 80;
  localparam int STALL_LIMIT = 5000;

  logic               clk_i, rst_ni, start_i, busy_o, cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [31:0]        cfg_wdata_i;
  logic signed [31:0] ray_x_i, ray_y_i, ray_z_i;
  logic               done_o, zero_depth_o, saturated_o;
  logic signed [31:0] pixel_x_o, pixel_y_o;
  int                 fail_count, pending, checked, sat_seen;
  int                 idle_pct, rays_sent, stall_cycles;

  pinhole_project_radial_distort DUT (.*);

  pprd_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .ray_x_i, .ray_y_i, .ray_z_i, .done_i(done_o), .pixel_x_i(pixel_x_o),
    .pixel_y_i(pixel_y_o), .zero_depth_i(zero_depth_o), .saturated_i(saturated_o),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked),
    .sat_seen_o(sat_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Drop out if nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one ray, with random idle cycles ahead of it; returns at a falling edge
  task automatic send_ray(input logic [31:0] x, y, z);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    ray_x_i <= x;
    ray_y_i <= y;
    ray_z_i <= z;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    rays_sent++;
    @(negedge clk_i);
  endtask

  // Hold off until the pipeline is empty, so that registers can be written
  task automatic drain();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic load_regs(input logic [31:0] f, a, s, cx, cy, q1, q2);
    write_reg(CFG_FOCAL, f);
    write_reg(CFG_ASPECT, a);
    write_reg(CFG_SKEW, s);
    write_reg(CFG_PRIN_X, cx);
    write_reg(CFG_PRIN_Y, cy);
    write_reg(CFG_K1, q1);
    write_reg(CFG_K2, q2);
    @(negedge clk_i);
  endtask

  // Either a plausible ray in front of or behind the camera, or raw random bits
  task automatic random_ray();
    logic signed [31:0] z;
    logic signed [31:0] span;
    if ($urandom_range(3) == 0) begin
      send_ray($urandom, $urandom, ($urandom_range(15) == 0) ? 32'd0 : $urandom);
    end else begin
      z    = $urandom_range(32'h0064_0000, 32'h0000_8000);
      span = z;
      if ($urandom_range(4) == 0) z = -z;
      send_ray($signed($urandom_range(2 * span)) - span,
               $signed($urandom_range(2 * span)) - span, z);
    end
  endtask

  initial begin
    start_i      = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_wdata_i  = '0;
    ray_x_i      = '0;
    ray_y_i      = '0;
    ray_z_i      = '0;
    rays_sent    = 0;
    idle_pct     = 31;
    rst_ni       = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed rays at reset settings: zero and negative depth, field extremes
    send_ray(32'h0001_0000, 32'h0002_0000, 32'h0000_0000);
    send_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    send_ray(32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
    send_ray(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000);
    send_ray(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000);
    send_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    send_ray(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
    send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_ray(32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000);
    send_ray(32'h0080_0000, 32'h0040_0000, 32'h0001_0000);
    drain();

    // Extreme registers: largest and zero gains, strongest distortion
    load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_ray(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_ray(32'hFFFF_0000, 32'h0000_8000, 32'h0004_0000);
    send_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    send_ray(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    drain();
    load_regs(32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_ray(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);
    send_ray(32'h0003_0000, 32'h0002_0000, 32'hFFFE_0000);
    send_ray(32'h0000_1000, 32'h0000_1000, 32'h0001_0000);
    drain();

    // Random phases: each takes a fresh register set and an idling rate
    for (int phase = 0; phase < 6; phase++) begin
      idle_pct = (phase < 2) ? 31 : (phase < 4) ? 58 : 0;
      if (phase % 3 == 0) begin
        load_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        load_regs($urandom_range(32'h0400_0000, 32'h0001_0000),
                  $urandom_range(32'h0002_0000, 32'h0000_8000),
                  $signed($urandom_range(32'h0002_0000)) - 32'sh0001_0000,
                  $urandom_range(32'h0200_0000), $urandom_range(32'h0200_0000),
                  $signed($urandom_range(32'h0800_0000)) - 32'sh0400_0000,
                  $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000);
      end
      for (int n = 0; n < RANDOM_RAYS / 6; n++) random_ray();
      drain();
    end

    $display("Sent %0d rays, checked %0d pixels, %0d of them saturated",
             rays_sent, checked, sat_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
